// ===== rtl/qpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_pkg
// Types, character codes and small helpers shared by the encoder modules.
// ----------------------------------------------------------------------------
package qpe_pkg;

    // character codes
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_US   = 8'h5F;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] LIT_MAX = 8'd126;   // highest byte passed literally
    localparam logic [7:0] CTL_MAX = 8'd32;    // bytes up to here are blanks/controls

    localparam logic [7:0] MAX_LINE_RESET = 8'd78;
    localparam logic [7:0] HDR_WRAP_COL   = 8'd11;  // column after a Q-word wrap
    localparam logic [3:0] HDR_WRAP_LEN   = 4'd14;  // "?=\n =?UTF-8?Q?"

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_BODY = 2'd1,
        WR_HDR  = 2'd2
    } t_wrap;

    typedef enum logic [1:0] {
        MK_LIT = 2'd0,
        MK_ESC = 2'd1,
        MK_NL  = 2'd2
    } t_main;

    // one classified input item
    typedef struct packed {
        t_wrap       wrap;   // soft break before the byte
        logic        pre;    // "=\n" ahead of a body newline after a blank
        t_main       main;   // how the byte itself goes out
        logic        close;  // closing "=\n" after the byte
        logic [7:0]  ch;     // byte (or '_' for a header space)
        logic [7:0]  col;    // column after the item
    } t_desc;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

    function automatic logic [7:0] hdr_wrap_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h3F;   // ?
            4'd1:    r = 8'h3D;   // =
            4'd2:    r = 8'h0A;   // LF
            4'd3:    r = 8'h20;   // space
            4'd4:    r = 8'h3D;   // =
            4'd5:    r = 8'h3F;   // ?
            4'd6:    r = 8'h55;   // U
            4'd7:    r = 8'h54;   // T
            4'd8:    r = 8'h46;   // F
            4'd9:    r = 8'h2D;   // -
            4'd10:   r = 8'h38;   // 8
            4'd11:   r = 8'h3F;   // ?
            4'd12:   r = 8'h51;   // Q
            4'd13:   r = 8'h3F;   // ?
            default: r = 8'h3F;
        endcase
        hdr_wrap_char = r;
    endfunction

    function automatic logic phrase_safe(input logic [7:0] c);
        phrase_safe = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                                 8'h21, 8'h2A, 8'h2B, 8'h2D, 8'h2F});
    endfunction

endpackage

// ===== rtl/quoted_printable_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_printable_encoder_top
// Quoted-printable / Q-word encoder, one input byte per item.
// ----------------------------------------------------------------------------
// The encoder emits one output character per clock while the consumer is
// ready. An input item is taken by the front end, which updates column state
// and classifies the byte; the back end then sends out its characters: one
// for a literal, three for an =XX escape, two more for a body soft break, a
// break ahead of a newline or a closing break, and fourteen more for a header
// Q-word wrap. A typical byte thus yields one to three characters, at most
// seventeen. The back end's single character per cycle sets the rate; the
// queue between the two ends lets new items be accepted while earlier ones are
// still going out, and the output register holds each character for the consumer.
// ----------------------------------------------------------------------------
module quoted_printable_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: max_line_len
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte, next_byte, start_column
    input  logic [2:0]  s_axis_tuser,   // has_next, first_byte, from_prefix
    input  logic        s_axis_tlast,   // last_byte
    // output items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_char, end_column
    output logic        m_axis_tlast    // run_end
);
    import qpe_pkg::*;

    logic  push, q_full, q_valid, q_pop;
    t_desc f_desc, q_desc;
    logic [7:0] o_char, o_col;

    // item accepted whenever the queue has room
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    qpe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_next_byte    (s_axis_tdata[15:8]),
        .i_has_next     (s_axis_tuser[0]),
        .i_first_byte   (s_axis_tuser[1]),
        .i_last_byte    (s_axis_tlast),
        .i_start_column (s_axis_tdata[23:16]),
        .i_from_prefix  (s_axis_tuser[2]),
        .o_desc         (f_desc)
    );

    qpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (f_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    qpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_desc),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (o_char),
        .o_last    (m_axis_tlast),
        .o_col     (o_col)
    );

    assign m_axis_tdata = {o_col, o_char};

endmodule

// ===== rtl/qpe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_front
// Keeps column / blank / mode state, decides wrap and byte encoding per item.
// ----------------------------------------------------------------------------
module qpe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic [7:0]    i_next_byte,
    input  logic          i_has_next,
    input  logic          i_first_byte,
    input  logic          i_last_byte,
    input  logic [7:0]    i_start_column,
    input  logic          i_from_prefix,
    output qpe_pkg::t_desc o_desc
);
    import qpe_pkg::*;

    logic [7:0] r_max, r_col;
    logic       r_pb, r_hdr;
    logic [7:0] n_col;
    logic       n_pb, n_hdr;

    logic [7:0] col_e, col_a, thresh;
    logic       pb_e, pb_a, wrap, next_eol, blank;
    logic [3:0] margin;
    logic [7:0] c;
    t_desc      d;

    assign c = i_data_byte;

    always_comb begin
        col_e = i_first_byte ? i_start_column : r_col;
        n_hdr = i_first_byte ? (i_start_column != 8'd0) : r_hdr;
        pb_e  = i_first_byte ? 1'b0 : r_pb;

        // margin from the UTF-8 lead bits
        if (c[7] == 1'b0)               margin = 4'd3;
        else if (c[7:6] == 2'b10)       margin = 4'd3;
        else if (c[7:5] == 3'b110)      margin = 4'd6;
        else if (c[7:4] == 4'b1110)     margin = 4'd9;
        else if (c[7:3] == 5'b11110)    margin = 4'd12;
        else                            margin = 4'd3;
        margin = margin + {3'd0, n_hdr};
        thresh = (r_max > {4'd0, margin}) ? (r_max - {4'd0, margin}) : 8'd0;

        wrap  = (col_e >= thresh);
        col_a = wrap ? (n_hdr ? HDR_WRAP_COL : 8'd0) : col_e;
        pb_a  = wrap ? 1'b0 : pb_e;

        next_eol = i_has_next && (i_next_byte == CH_LF || i_next_byte == CH_CR);
        blank    = (c == CH_SP) || (c == CH_TAB);

        d       = '0;
        d.wrap  = wrap ? (n_hdr ? WR_HDR : WR_BODY) : WR_NONE;
        d.ch    = c;
        d.main  = MK_ESC;
        n_col   = col_a + 8'd3;
        n_pb    = 1'b0;

        if (c > LIT_MAX || c == CH_EQ ||
            (col_a == 8'd0 && (i_from_prefix || (c == CH_DOT && next_eol)))) begin
            n_pb = blank;
        end else if (n_hdr && (c == CH_LF || c == CH_TAB || c == CH_US)) begin
            n_pb = 1'b0;
        end else if (n_hdr && c == CH_SP) begin
            d.main = MK_LIT;
            d.ch   = CH_US;
            n_col  = col_a + 8'd1;
        end else if (c <= CTL_MAX && c != CH_LF) begin
            if (blank && i_has_next && !next_eol) begin
                d.main = MK_LIT;
                n_col  = col_a + 8'd1;
                n_pb   = 1'b1;
            end
        end else if (c == CH_LF) begin
            d.main = MK_NL;
            d.pre  = pb_a;
            n_col  = 8'd0;
        end else if (n_hdr && !phrase_safe(c)) begin
            n_pb = 1'b0;
        end else begin
            d.main = MK_LIT;
            n_col  = col_a + 8'd1;
        end

        d.col   = n_col;
        d.close = i_last_byte && (n_col != 8'd0) && !n_hdr;
        o_desc  = d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_LINE_RESET;
            r_col <= 8'd0;
            r_pb  <= 1'b0;
            r_hdr <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_push) begin
                r_col <= n_col;
                r_pb  <= n_pb;
                r_hdr <= n_hdr;
            end
        end
    end

endmodule

// ===== rtl/qpe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module qpe_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qpe_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output qpe_pkg::t_desc o_desc
);
    import qpe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/qpe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_back
// Walks a classified item, one char per cycle unless stalled, into a register.
// ----------------------------------------------------------------------------
module qpe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  qpe_pkg::t_desc i_q_desc,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_last,
    output logic [7:0]     o_col
);
    import qpe_pkg::*;

    typedef enum logic [3:0] {
        PH_WRAP  = 4'b0001,
        PH_PRE   = 4'b0010,
        PH_MAIN  = 4'b0100,
        PH_CLOSE = 4'b1000
    } t_phase;

    t_desc      r_desc;
    t_phase     r_phase, ph_next, ph_first;
    logic [3:0] r_idx, plen;
    logic       r_busy, done_next, issue, at_end, ch_last;
    logic [7:0] ch;
    logic       r_ovalid, r_olast;
    logic [7:0] r_ochar, r_ocol;

    assign issue = r_busy && (!r_ovalid || i_ready);

    always_comb begin
        plen      = 4'd2;
        ch        = CH_EQ;
        ph_next   = PH_MAIN;
        done_next = 1'b0;
        case (r_phase)
            PH_WRAP: begin
                if (r_desc.wrap == WR_HDR) begin
                    plen = HDR_WRAP_LEN;
                    ch   = hdr_wrap_char(r_idx);
                end else begin
                    ch = (r_idx == 4'd0) ? CH_EQ : CH_LF;
                end
                ph_next = r_desc.pre ? PH_PRE : PH_MAIN;
            end
            PH_PRE: begin
                ch      = (r_idx == 4'd0) ? CH_EQ : CH_LF;
                ph_next = PH_MAIN;
            end
            PH_MAIN: begin
                case (r_desc.main)
                    MK_ESC: begin
                        plen = 4'd3;
                        if (r_idx == 4'd0)      ch = CH_EQ;
                        else if (r_idx == 4'd1) ch = hex_char(r_desc.ch[7:4]);
                        else                    ch = hex_char(r_desc.ch[3:0]);
                    end
                    MK_NL: begin
                        plen = 4'd1;
                        ch   = CH_LF;
                    end
                    default: begin
                        plen = 4'd1;
                        ch   = r_desc.ch;
                    end
                endcase
                ph_next   = PH_CLOSE;
                done_next = !r_desc.close;
            end
            PH_CLOSE: begin
                ch        = (r_idx == 4'd0) ? CH_EQ : CH_LF;
                done_next = 1'b1;
            end
            default: begin
                done_next = 1'b1;
            end
        endcase
    end

    assign at_end  = (r_idx == plen - 4'd1);
    assign ch_last = at_end && done_next;
    assign o_q_pop = i_q_valid && (!r_busy || (issue && ch_last));

    always_comb begin
        if (i_q_desc.wrap != WR_NONE) ph_first = PH_WRAP;
        else if (i_q_desc.pre)        ph_first = PH_PRE;
        else                          ph_first = PH_MAIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_MAIN;
            r_idx    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy  <= 1'b1;
                r_phase <= ph_first;
                r_idx   <= 4'd0;
            end else if (issue && ch_last) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                if (at_end) begin
                    r_phase <= ph_next;
                    r_idx   <= 4'd0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
            if (issue) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_desc <= i_q_desc;
        end
        if (issue) begin
            r_ochar <= ch;
            r_olast <= ch_last;
            r_ocol  <= r_desc.col;
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;
    assign o_col   = r_ocol;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quoted-printable / Q-word encoder.
// ----------------------------------------------------------------------------
// Byte items go in from a queue that the stimulus process fills. The source
// driver feeds them to the slave port. Each accepted byte is run through a
// behavioral encoder here, which appends its output characters to a queue.
// The sink monitor pops that queue for every character the block emits and
// compares char, run_end and end column. Both ports stall in random bursts,
// except in the final phase. The line limit is changed only between phases,
// once every expected character has come out.
// ----------------------------------------------------------------------------
module tb;

    // character codes
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] LIT_TOP = 8'd126;   // highest byte sent as is
    localparam logic [7:0] LINE_MAX_RESET = 8'd78;

    // Q-word soft break, first character in the top bits
    localparam int QWORD_WRAP_LEN = 14;
    localparam logic [QWORD_WRAP_LEN*8-1:0] QWORD_WRAP = "?=\n =?UTF-8?Q?";
    localparam int QWORD_WRAP_COL = 11;

    localparam int TAIL_CYCLES = 100;

    typedef struct {
        logic [7:0] data_byte;
        logic [7:0] next_byte;
        logic       has_next;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] start_column;
        logic       from_prefix;
    } t_qp_byte;

    typedef struct {
        logic [7:0] out_char;
        logic       run_end;
        logic [7:0] end_column;
    } t_qp_char;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 24'd0;   // data_byte, next_byte, start_column
    logic [2:0]  s_axis_tuser = 3'd0;    // has_next, first_byte, from_prefix
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // out_char, end_column
    logic        m_axis_tlast;           // run_end

    always #1 i_clk = ~i_clk;

    quoted_printable_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------
    t_qp_byte   byte_items[$];       // bytes waiting for the driver
    t_qp_char   expected_chars[$];   // encoder output still to come
    t_qp_byte   cur_item;
    t_qp_char   exp_char;
    int         n_queued = 0;
    int         n_accepted = 0;
    int         n_err = 0;
    int         src_gap = 0;
    int         sink_gap = 0;
    bit         idle_on = 1'b1;

    // encoder state mirror
    logic [7:0] line_max = LINE_MAX_RESET;
    int         col_now = 0;
    bit         blank_prev = 1'b0;
    bit         hdr_mode = 1'b0;
    logic [7:0] step_chars[$];

    // ------------------------------------------------------------------
    // behavioral encoder
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? CH_0 + {4'd0, v} : CH_A + {4'd0, v} - 8'd10;
    endfunction

    function automatic void add_escape(input logic [7:0] c);
        step_chars.push_back(CH_EQ);
        step_chars.push_back(hex_digit(c[7:4]));
        step_chars.push_back(hex_digit(c[3:0]));
    endfunction

    function automatic bit q_word_safe(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "!" || c == "*" || c == "+" ||
               c == "-" || c == "/";
    endfunction

    function automatic void encode_byte(input t_qp_byte it);
        int         margin;
        int         thresh;
        int         i;
        bit         eol_next;
        logic [7:0] c;
        t_qp_char   r;

        c = it.data_byte;
        eol_next = it.has_next && (it.next_byte == CH_LF || it.next_byte == CH_CR);
        step_chars.delete();

        if (it.first_byte) begin
            col_now = it.start_column;
            hdr_mode = (it.start_column != 8'd0);
            blank_prev = 1'b0;
        end

        // margin keeps a whole UTF-8 sequence on one line
        if (c[7] == 1'b0)              margin = 3;
        else if (c[7:6] == 2'b10)      margin = 3;
        else if (c[7:5] == 3'b110)     margin = 6;
        else if (c[7:4] == 4'b1110)    margin = 9;
        else if (c[7:3] == 5'b11110)   margin = 12;
        else                           margin = 3;
        margin += hdr_mode;
        thresh = (int'(line_max) > margin) ? int'(line_max) - margin : 0;

        if (col_now >= thresh) begin
            col_now = 0;
            blank_prev = 1'b0;
            if (hdr_mode) begin
                for (i = 0; i < QWORD_WRAP_LEN; i++)
                    step_chars.push_back(QWORD_WRAP[(QWORD_WRAP_LEN-1-i)*8 +: 8]);
                col_now = QWORD_WRAP_COL;
            end else begin
                step_chars.push_back(CH_EQ);
                step_chars.push_back(CH_LF);
            end
        end

        if (c > LIT_TOP || c == CH_EQ ||
            (col_now == 0 && (it.from_prefix || (c == CH_DOT && eol_next)))) begin
            add_escape(c);
            col_now += 3;
            blank_prev = (c == CH_SP || c == CH_TAB);
        end else if (hdr_mode && (c == CH_LF || c == CH_TAB || c == CH_US)) begin
            add_escape(c);
            col_now += 3;
            blank_prev = 1'b0;
        end else if (hdr_mode && c == CH_SP) begin
            step_chars.push_back(CH_US);
            col_now += 1;
            blank_prev = 1'b0;
        end else if (c < 8'd33 && c != CH_LF) begin
            if ((c == CH_SP || c == CH_TAB) && it.has_next && !eol_next) begin
                step_chars.push_back(c);
                col_now += 1;
                blank_prev = 1'b1;
            end else begin
                add_escape(c);
                col_now += 3;
                blank_prev = 1'b0;
            end
        end else if (c == CH_LF) begin
            if (blank_prev) begin
                step_chars.push_back(CH_EQ);
                step_chars.push_back(CH_LF);
            end
            step_chars.push_back(CH_LF);
            col_now = 0;
            blank_prev = 1'b0;
        end else if (hdr_mode && !q_word_safe(c)) begin
            add_escape(c);
            col_now += 3;
            blank_prev = 1'b0;
        end else begin
            step_chars.push_back(c);
            col_now += 1;
            blank_prev = 1'b0;
        end

        col_now = col_now & 255;

        if (it.last_byte && col_now > 0 && !hdr_mode) begin
            step_chars.push_back(CH_EQ);
            step_chars.push_back(CH_LF);
        end

        for (i = 0; i < step_chars.size(); i++) begin
            r.out_char = step_chars[i];
            r.run_end = (i == step_chars.size() - 1);
            r.end_column = col_now[7:0];
            expected_chars.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_one(input logic [7:0] d, input logic [7:0] nx,
                                      input bit hn, input bit fst, input bit lst,
                                      input logic [7:0] sc, input bit pfx);
        t_qp_byte it;
        it.data_byte = d;
        it.next_byte = nx;
        it.has_next = hn;
        it.first_byte = fst;
        it.last_byte = lst;
        it.start_column = sc;
        it.from_prefix = pfx;
        byte_items.push_back(it);
        n_queued++;
    endfunction

    // mostly text, with a fair share of blanks, line ends and 8-bit bytes
    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14)      return CH_LA + 8'($urandom_range(0, 25));
        else if (r < 26) return CH_A + 8'($urandom_range(0, 25));
        else if (r < 36) return CH_0 + 8'($urandom_range(0, 9));
        else if (r < 46) return CH_SP;
        else if (r < 51) return CH_TAB;
        else if (r < 57) return CH_LF;
        else if (r < 60) return CH_CR;
        else if (r < 65) return CH_DOT;
        else if (r < 69) return CH_EQ;
        else if (r < 72) return CH_US;
        else if (r < 85) return 8'($urandom_range(128, 255));
        else if (r < 93) return 8'($urandom_range(33, 126));
        else             return 8'($urandom);
    endfunction

    // Whole buffers with random content, some broken, some pure noise.
    function automatic void queue_random(input int target);
        int         made;
        int         kind;
        int         len;
        int         i;
        int         flaw;
        logic [7:0] start;
        logic [7:0] nx;
        bit         pfx;
        logic [7:0] text[$];

        made = 0;
        while (made < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                queue_one(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom), 8'($urandom), 1'($urandom));
                made++;
            end else begin
                // 0: well formed, 1: no first, 2: no last, 3: bogus lookahead
                flaw = (kind < 25) ? $urandom_range(1, 3) : 0;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 30);
                // keep the phase at its item budget
                if (len > target - made)
                    len = target - made;
                if ($urandom_range(0, 2) == 0)
                    start = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(1, 40));
                else
                    start = 8'd0;
                pfx = ($urandom_range(0, 4) == 0);
                text.delete();
                for (i = 0; i < len; i++)
                    text.push_back(text_byte());
                for (i = 0; i < len; i++) begin
                    nx = (i + 1 < len && flaw != 3) ? text[i+1] : 8'($urandom);
                    queue_one(text[i], nx,
                              (flaw == 3) ? 1'($urandom) : (i + 1 < len),
                              i == 0 && flaw != 1,
                              i == len - 1 && flaw != 2,
                              (i == 0) ? start : 8'($urandom),
                              pfx);
                end
                made += len;
            end
        end
    endfunction

    // the limit only moves while nothing is in flight
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_chars.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_line_max(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        line_max = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // source driver: one item from the queue per handshake
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_byte(cur_item);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (byte_items.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    // insert an idle gap
                    s_axis_tvalid <= 1'b0;
                    src_gap <= $urandom_range(0, 8);
                end else begin
                    cur_item = byte_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur_item.start_column, cur_item.next_byte,
                                     cur_item.data_byte};
                    s_axis_tuser <= {cur_item.from_prefix, cur_item.first_byte,
                                     cur_item.has_next};
                    s_axis_tlast <= cur_item.last_byte;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sink monitor: checks every emitted char against the oldest expected
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: unexpected char %h run_end %b col %0d", $time,
                                 m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[15:8]);
                end else begin
                    exp_char = expected_chars.pop_front();
                    if (m_axis_tdata[7:0] !== exp_char.out_char ||
                        m_axis_tlast !== exp_char.run_end ||
                        m_axis_tdata[15:8] !== exp_char.end_column) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("%0t: char %h/%h run_end %b/%b col %0d/%0d (exp/got)",
                                     $time, exp_char.out_char, m_axis_tdata[7:0],
                                     exp_char.run_end, m_axis_tlast,
                                     exp_char.end_column, m_axis_tdata[15:8]);
                    end
                end
            end
            if (sink_gap > 0) begin
                m_axis_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                // insert a ready stall
                m_axis_tready <= 1'b0;
                sink_gap <= $urandom_range(0, 8);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus phases
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset limit of 78. First byte goes without first_byte:
        // body mode and column 0 straight out of reset. 'From ' escapes.
        queue_one("F", "r", 1, 0, 0, 8'd0, 1);
        queue_one("r", " ", 1, 0, 1, 8'd0, 1);           // closing soft break
        queue_one(CH_SP, "a", 1, 1, 0, 8'd0, 0);         // literal blank
        queue_one(CH_LF, CH_DOT, 1, 0, 0, 8'd0, 0);      // break ahead of newline
        queue_one(CH_DOT, CH_LF, 1, 0, 0, 8'd0, 0);      // lone dot line
        queue_one(CH_LF, CH_TAB, 1, 0, 0, 8'd0, 0);
        queue_one(CH_TAB, CH_CR, 1, 0, 0, 8'd0, 0);      // blank before CR
        queue_one(CH_SP, 8'hA5, 0, 0, 0, 8'd0, 0);       // blank at buffer end
        queue_one(8'h00, 8'hFF, 1, 0, 0, 8'd0, 0);
        queue_one(8'hFF, CH_EQ, 1, 0, 0, 8'd0, 0);
        queue_one(CH_EQ, 8'h7F, 1, 0, 0, 8'd0, 0);
        queue_one(8'h7F, "~", 1, 0, 0, 8'd0, 0);
        queue_one("~", "!", 1, 0, 0, 8'd0, 0);
        queue_one(8'hC3, 8'hE2, 1, 0, 0, 8'd0, 0);       // UTF-8 leads
        queue_one(8'hE2, 8'hF0, 1, 0, 0, 8'd0, 0);
        queue_one(8'hF0, 8'hF8, 1, 0, 0, 8'd0, 0);
        queue_one(8'hF8, 8'h80, 1, 0, 1, 8'd0, 0);
        // header mode: Q-word rules, no closing break
        queue_one(CH_SP, CH_US, 1, 1, 0, 8'd40, 0);
        queue_one(CH_US, CH_TAB, 1, 0, 0, 8'd40, 0);
        queue_one(CH_TAB, CH_LF, 1, 0, 0, 8'd40, 0);
        queue_one(CH_LF, "(", 1, 0, 0, 8'd40, 0);
        queue_one("(", "a", 1, 0, 0, 8'd40, 0);
        queue_one("a", 8'h00, 0, 0, 1, 8'd40, 0);
        queue_one("Z", 8'h00, 0, 1, 1, 8'd255, 0);      // start past the limit
        queue_one("q", 8'h00, 0, 0, 1, 8'd0, 0);         // header mode carried
        wait_drained();

        // limit below the margin: threshold saturates at zero
        set_line_max(8'd10);
        queue_one("a", 8'hF0, 1, 1, 0, 8'd0, 0);
        queue_one(8'hF0, 8'hC3, 1, 0, 0, 8'd0, 0);
        queue_one(8'hC3, "b", 1, 0, 1, 8'd0, 0);
        queue_one(CH_SP, 8'hE2, 1, 1, 0, 8'd5, 0);
        queue_one(8'hE2, "b", 1, 0, 0, 8'd5, 0);
        queue_one("b", 8'h00, 0, 0, 1, 8'd5, 0);
        wait_drained();

        set_line_max(8'd20);
        queue_random(100);
        wait_drained();

        set_line_max(8'd255);
        queue_random(100);
        wait_drained();

        set_line_max(8'($urandom_range(20, 255)));
        queue_random(100);
        wait_drained();

        // last stretch at full rate on both ports
        idle_on = 1'b0;
        set_line_max(8'($urandom_range(20, 80)));
        queue_random(90);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_err == 0 && expected_chars.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qpe_pkg.sv
rtl/qpe_front.sv
rtl/qpe_queue.sv
rtl/qpe_back.sv
rtl/quoted_printable_encoder_top.sv
tb/tb.sv
